/* sv/decimated_pid_antiwindup_unit_assert.svh */
// assertion macros used by the checker file of the pid unit
// needs nothing else; each macro expands to one labeled concurrent assertion
`ifndef DECIMATED_PID_ANTIWINDUP_UNIT_ASSERT_SVH
`define DECIMATED_PID_ANTIWINDUP_UNIT_ASSERT_SVH

// checked only outside reset
`define DPAW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define DPAW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/dpaw_pkg.sv */
// shared types and constants of the decimated pid unit
// used by every module of the block; depends on nothing
package dpaw_pkg;

   localparam int DATA_W        = 32;
   localparam int CNT_W         = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int REG_IDX_W     = 3;

   // register indexes of the configuration port
   localparam logic [REG_IDX_W-1:0] REG_TICKS_PER_UPDATE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP        = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_INT_STEP    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DERIV_COEF_NOW   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DERIV_COEF_PREV  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DERIV_COEF_FB    = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_LIMIT_HIGH       = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_LIMIT_LOW        = 3'd7;

   // reset values of the limits
   localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RST = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] LIMIT_LOW_RST  = 32'sh8000_0000;

   typedef struct packed {
      logic        [CNT_W-1:0]  ticks_per_update;
      logic signed [DATA_W-1:0] gain_prop;
      logic signed [DATA_W-1:0] gain_int_step;
      logic signed [DATA_W-1:0] deriv_coef_now;
      logic signed [DATA_W-1:0] deriv_coef_prev;
      logic signed [DATA_W-1:0] deriv_coef_fb;
      logic signed [DATA_W-1:0] limit_high;
      logic signed [DATA_W-1:0] limit_low;
   } cfg_type;

   // update request handed from the tick stage to the math stage
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] error;
   } stage_type;

endpackage

/* sv/dpaw_csr.sv */
// configuration registers of the decimated pid unit
// depends on dpaw_pkg for the register indexes and the cfg_type struct
module dpaw_csr
   import dpaw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_TICKS_PER_UPDATE: cfg_in.ticks_per_update = csr_wdata[CNT_W-1:0];
            REG_GAIN_PROP:        cfg_in.gain_prop        = csr_wdata;
            REG_GAIN_INT_STEP:    cfg_in.gain_int_step    = csr_wdata;
            REG_DERIV_COEF_NOW:   cfg_in.deriv_coef_now   = csr_wdata;
            REG_DERIV_COEF_PREV:  cfg_in.deriv_coef_prev  = csr_wdata;
            REG_DERIV_COEF_FB:    cfg_in.deriv_coef_fb    = csr_wdata;
            REG_LIMIT_HIGH:       cfg_in.limit_high       = csr_wdata;
            REG_LIMIT_LOW:        cfg_in.limit_low        = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_update <= CNT_W'(1);
         cfg_ff.gain_prop        <= '0;
         cfg_ff.gain_int_step    <= '0;
         cfg_ff.deriv_coef_now   <= '0;
         cfg_ff.deriv_coef_prev  <= '0;
         cfg_ff.deriv_coef_fb    <= '0;
         cfg_ff.limit_high       <= LIMIT_HIGH_RST;
         cfg_ff.limit_low        <= LIMIT_LOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/dpaw_tick.sv */
// tick decimator and input register of the decimated pid unit
// depends on dpaw_pkg; passes only update ticks on to the math stage
module dpaw_tick
   import dpaw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [CNT_W-1:0]  ticks_per_update,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,
   output stage_type         stage,
   input  logic              stage_ready
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] count_next;
   logic             update_tick;
   logic             accept;
   logic             stage_valid_ff;
   logic             stage_valid_in;
   logic [DATA_W-1:0] error_ff;

   // input register frees up when the math stage takes it
   assign req_tready = !stage_valid_ff || stage_ready;
   assign accept     = req_tvalid && req_tready;

   // wrapping tick count; the update tick clears it
   assign count_next  = count_ff + CNT_W'(1);
   assign update_tick = (count_next >= ticks_per_update);

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = update_tick ? '0 : count_next;
      end
   end

   // only update ticks become a request to the math stage
   assign stage_valid_in = (accept && update_tick) || (stage_valid_ff && !stage_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         count_ff       <= count_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // error payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept && update_tick) begin
         error_ff <= req_tdata;
      end
   end

   assign stage.valid = stage_valid_ff;
   assign stage.error = error_ff;

endmodule

/* sv/dpaw_core.sv */
// pid math, controller state and result register of the decimated pid unit
// depends on dpaw_pkg; one registered pass per update request
module dpaw_core
   import dpaw_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  stage_type         stage,
   output logic              stage_ready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,
   output logic              rsp_tuser
);

   // shifted product width and exact sum width
   localparam int PROD_W = 2 * DATA_W - FRAC_BITS;
   localparam int ACC_W  = PROD_W + 3;

   localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(32'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(32'sh8000_0000);

   logic signed [DATA_W-1:0] integ_ff,  integ_in;
   logic signed [DATA_W-1:0] pderiv_ff, pderiv_in;
   logic signed [DATA_W-1:0] perr_ff,   perr_in;
   logic                     valid_ff,  valid_in;
   logic [DATA_W-1:0]        drive_ff;
   logic                     sat_ff;

   logic signed [2*DATA_W-1:0] mul_p, mul_i, mul_dn, mul_dp, mul_df;
   logic signed [PROD_W-1:0]   q_p, q_i, q_dn, q_dp, q_df;
   logic signed [ACC_W-1:0]    integ_sum, deriv_sum, out_sum;
   logic signed [DATA_W-1:0]   integ_new, deriv_clamped, drive_new;
   logic                       sat_new;
   logic                       take;

   // clamp to the configured limits, upper limit tested first
   function automatic logic signed [DATA_W-1:0] clamp_lim(
      input logic signed [ACC_W-1:0]  v,
      input logic signed [DATA_W-1:0] hi,
      input logic signed [DATA_W-1:0] lo
   );
      logic signed [DATA_W-1:0] r;
      if (v > ACC_W'(hi)) begin
         r = hi;
      end else if (v < ACC_W'(lo)) begin
         r = lo;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   assign stage_ready = !valid_ff || rsp_tready;
   assign take        = stage.valid && stage_ready;

   // exact products, floor-shifted back to the fixed point scale
   assign mul_p  = cfg.gain_prop       * stage.error;
   assign mul_i  = cfg.gain_int_step   * stage.error;
   assign mul_dn = cfg.deriv_coef_now  * stage.error;
   assign mul_dp = cfg.deriv_coef_prev * perr_ff;
   assign mul_df = cfg.deriv_coef_fb   * pderiv_ff;

   assign q_p  = PROD_W'(mul_p  >>> FRAC_BITS);
   assign q_i  = PROD_W'(mul_i  >>> FRAC_BITS);
   assign q_dn = PROD_W'(mul_dn >>> FRAC_BITS);
   assign q_dp = PROD_W'(mul_dp >>> FRAC_BITS);
   assign q_df = PROD_W'(mul_df >>> FRAC_BITS);

   // integrator with anti-windup clamp
   assign integ_sum = ACC_W'(integ_ff) + ACC_W'(q_i);
   assign integ_new = clamp_lim(integ_sum, cfg.limit_high, cfg.limit_low);

   // derivative filter; the stored copy is clamped, the output is not
   assign deriv_sum     = ACC_W'(q_dn) + ACC_W'(q_dp) + ACC_W'(q_df);
   assign deriv_clamped = clamp_lim(deriv_sum, cfg.limit_high, cfg.limit_low);

   // output sum with saturation to the 32-bit range
   assign out_sum = ACC_W'(integ_new) + ACC_W'(q_p) + deriv_sum;

   always_comb begin
      sat_new   = 1'b0;
      drive_new = out_sum[DATA_W-1:0];
      if (out_sum > OUT_MAX) begin
         drive_new = OUT_MAX[DATA_W-1:0];
         sat_new   = 1'b1;
      end else if (out_sum < OUT_MIN) begin
         drive_new = OUT_MIN[DATA_W-1:0];
         sat_new   = 1'b1;
      end
   end

   // controller state moves only on a taken update
   assign integ_in  = take ? integ_new     : integ_ff;
   assign pderiv_in = take ? deriv_clamped : pderiv_ff;
   assign perr_in   = take ? stage.error   : perr_ff;
   assign valid_in  = take || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff  <= '0;
         pderiv_ff <= '0;
         perr_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         integ_ff  <= integ_in;
         pderiv_ff <= pderiv_in;
         perr_ff   <= perr_in;
         valid_ff  <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take) begin
         drive_ff <= drive_new;
         sat_ff   <= sat_new;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = drive_ff;
   assign rsp_tuser  = sat_ff;

endmodule

/* sv/decimated_pid_antiwindup_unit.sv */
// top level of the decimated pid controller with integrator clamp
// depends on dpaw_pkg, dpaw_csr, dpaw_tick and dpaw_core
// usage:
//   req channel carries one timer tick per request, with the error sample
//   (signed fixed point, FRAC_BITS fraction bits) in req_tdata.
//   every ticks_per_update-th tick (every tick when the ratio is zero) runs
//   the controller; other ticks are consumed and give no response.
//   rsp channel returns drive in rsp_tdata and the saturation flag in
//   rsp_tuser, one response per update tick, in order.
//   csr port: csr_we writes csr_wdata to register csr_index at the clock
//   edge; write only while no request is in flight.
// timing:
//   an accepted update tick is held in the input register, then passes the math
//   into the result register, which drives rsp_tvalid; one request per cycle
//   is accepted while req_tready stays high, set by the single pass of the multipliers, integrator clamp
//   and output sum into the result register, which closes the state loop.
// reset: synchronous, clears tick count, integrator, stored derivative,
//   previous error and all valid flags; registers go to their reset values.
// stall: a stalled response holds; one update request waits in the input
//   register, then req_tready drops until rsp_tready returns.
module decimated_pid_antiwindup_unit
   import dpaw_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,   // [31:0] error_sample
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,   // [31:0] drive
   output logic                 rsp_tuser,   // [0] out_saturated
   input  logic                 csr_we,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   cfg_type   cfg;
   stage_type stage;
   logic      stage_ready;

   // configuration registers
   dpaw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // tick decimation and input register
   dpaw_tick u_tick (
      .clock            (clock),
      .reset            (reset),
      .ticks_per_update (cfg.ticks_per_update),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .stage            (stage),
      .stage_ready      (stage_ready)
   );

   // controller math and result register
   dpaw_core #(
      .FRAC_BITS (FRAC_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage       (stage),
      .stage_ready (stage_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

/* sv/dpaw_check.sv */
// port-level checker of the decimated pid unit, bound to the top level
// depends on dpaw_pkg and the assertion macros header
`include "decimated_pid_antiwindup_unit_assert.svh"

module dpaw_check
   import dpaw_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [DATA_W-1:0]    rsp_tdata,
   input logic                 rsp_tuser
);

   // a stalled response keeps its payload
   property p_rsp_hold;
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser);
   endproperty

   // saturation flag goes only with a full-scale drive
   property p_sat_value;
      rsp_tvalid && rsp_tuser |->
         rsp_tdata == 32'h7FFF_FFFF || rsp_tdata == 32'h8000_0000;
   endproperty

   // nothing is offered right after reset
   property p_rst_empty;
      $past(reset) |-> !rsp_tvalid;
   endproperty

   // with the response side empty, the input side is never blocked
   property p_ready_when_empty;
      !rsp_tvalid |-> req_tready;
   endproperty

   `DPAW_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "stalled response changed")
   `DPAW_ASSERT(a_sat_value, clock, reset, p_sat_value, "saturated drive not at full scale")
   `DPAW_ASSERT_ALWAYS(a_rst_empty, clock, p_rst_empty, "response valid after reset")
   `DPAW_ASSERT(a_ready_when_empty, clock, reset, p_ready_when_empty, "request blocked")

endmodule

bind decimated_pid_antiwindup_unit dpaw_check u_check (.*);

/* verif/tb_decimated_pid_antiwindup_unit.sv */
`timescale 1ns / 1ps
// self-checking testbench of decimated_pid_antiwindup_unit, error ticks in, drive values out
// depends on dpaw_pkg and the unit; a local controller copy predicts every drive value
module tb_decimated_pid_antiwindup_unit;
   import dpaw_pkg::*;

   localparam int     FRAC        = FRAC_BITS_DEF;
   localparam int     SETTLE      = 8;
   localparam int     CYCLE_LIMIT = 400000;
   localparam int     HOLD_CYCLES = 200;
   localparam longint OUT_MAX     = 64'sd2147483647;
   localparam longint OUT_MIN     = -64'sd2147483648;

   typedef struct packed {
      logic [DATA_W-1:0] drive;
      logic              saturated;
   } drive_result_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata  = '0;    // [31:0] error_sample
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_W-1:0]    rsp_tdata;          // [31:0] drive
   logic                 rsp_tuser;          // [0] out_saturated
   logic                 csr_we     = 1'b0;
   logic [REG_IDX_W-1:0] csr_index  = '0;
   logic [DATA_W-1:0]    csr_wdata  = '0;

   // local copy of the controller registers and state
   cfg_type                  model_cfg;
   logic [CNT_W-1:0]         tick_cnt;
   logic signed [DATA_W-1:0] integ_state;
   logic signed [DATA_W-1:0] deriv_state;
   logic signed [DATA_W-1:0] error_state;

   drive_result_type pending_drive[$];

   int          idle_pct        = 0;
   int          stall_pct       = 0;
   int          hold_request    = 0;
   int          hold_left       = 0;
   int unsigned cycle_count     = 0;
   int          failures        = 0;
   int          ticks_sent      = 0;
   int          updates_checked = 0;
   int          saturated_seen  = 0;

   decimated_pid_antiwindup_unit #(.FRAC_BITS(FRAC)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d updates still pending",
                  cycle_count, pending_drive.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic longint wide(input logic [DATA_W-1:0] v);
      return longint'($signed(v));
   endfunction

   // product of two fixed point values, floor of the dropped fraction
   function automatic longint scaled_product(input longint a, input longint b);
      return (a * b) >>> FRAC;
   endfunction

   // upper limit is tested first, which decides crossed limits
   function automatic longint clamp_to_limits(input longint v);
      if (v > wide(model_cfg.limit_high)) return wide(model_cfg.limit_high);
      if (v < wide(model_cfg.limit_low)) return wide(model_cfg.limit_low);
      return v;
   endfunction

   // one tick through the controller copy; returns 1 when the tick updates
   function automatic bit predict_update(input logic [DATA_W-1:0] err,
                                         output drive_result_type res);
      logic [CNT_W-1:0] next_cnt;
      longint           e, p, d, v, total;
      res      = '0;
      next_cnt = tick_cnt + 1'b1;
      if (next_cnt < model_cfg.ticks_per_update) begin
         tick_cnt = next_cnt;
         return 1'b0;
      end
      tick_cnt = '0;
      e = wide(err);
      p = scaled_product(wide(model_cfg.gain_prop), e);
      v = clamp_to_limits(wide(integ_state) + scaled_product(wide(model_cfg.gain_int_step), e));
      integ_state = v[DATA_W-1:0];
      d = scaled_product(wide(model_cfg.deriv_coef_now), e)
          + scaled_product(wide(model_cfg.deriv_coef_prev), wide(error_state))
          + scaled_product(wide(model_cfg.deriv_coef_fb), wide(deriv_state));
      v = clamp_to_limits(d);
      deriv_state = v[DATA_W-1:0];
      error_state = err;
      // output uses the unclamped derivative
      total = wide(integ_state) + p + d;
      if (total > OUT_MAX) begin
         total         = OUT_MAX;
         res.saturated = 1'b1;
      end else if (total < OUT_MIN) begin
         total         = OUT_MIN;
         res.saturated = 1'b1;
      end
      res.drive = total[DATA_W-1:0];
      return 1'b1;
   endfunction

   task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want_v,
                                input logic [DATA_W-1:0] got_v);
      if (failures < 10)
         $display("mismatch on %s at update %0d: expected %h, got %h",
                  what, updates_checked, want_v, got_v);
      failures++;
   endtask

   // response checker
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_drive.size() == 0) begin
            note_mismatch("response with no pending update", '0, rsp_tdata);
         end else begin
            want = pending_drive.pop_front();
            if (rsp_tuser) saturated_seen++;
            if (rsp_tdata !== want.drive) note_mismatch("drive", want.drive, rsp_tdata);
            if (rsp_tuser !== want.saturated)
               note_mismatch("out_saturated", DATA_W'(want.saturated), DATA_W'(rsp_tuser));
            updates_checked++;
         end
      end
   end

   // offer one tick request, wait for its acceptance, then predict it
   task automatic send_tick(input logic [DATA_W-1:0] err);
      drive_result_type res;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= err;
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
      if (predict_update(err, res)) pending_drive.push_back(res);
   endtask

   // stop offering and let every pending update come out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_TICKS_PER_UPDATE: model_cfg.ticks_per_update = val[CNT_W-1:0];
         REG_GAIN_PROP:        model_cfg.gain_prop        = val;
         REG_GAIN_INT_STEP:    model_cfg.gain_int_step    = val;
         REG_DERIV_COEF_NOW:   model_cfg.deriv_coef_now   = val;
         REG_DERIV_COEF_PREV:  model_cfg.deriv_coef_prev  = val;
         REG_DERIV_COEF_FB:    model_cfg.deriv_coef_fb    = val;
         REG_LIMIT_HIGH:       model_cfg.limit_high       = val;
         REG_LIMIT_LOW:        model_cfg.limit_low        = val;
         default: ;
      endcase
   endtask

   task automatic write_config(input cfg_type c);
      write_reg(REG_TICKS_PER_UPDATE, DATA_W'(c.ticks_per_update));
      write_reg(REG_GAIN_PROP, c.gain_prop);
      write_reg(REG_GAIN_INT_STEP, c.gain_int_step);
      write_reg(REG_DERIV_COEF_NOW, c.deriv_coef_now);
      write_reg(REG_DERIV_COEF_PREV, c.deriv_coef_prev);
      write_reg(REG_DERIV_COEF_FB, c.deriv_coef_fb);
      write_reg(REG_LIMIT_HIGH, c.limit_high);
      write_reg(REG_LIMIT_LOW, c.limit_low);
   endtask

   // mostly small magnitudes so the loop stays out of saturation, sometimes full range
   function automatic logic [DATA_W-1:0] random_value(input int unsigned full_pct);
      int unsigned       bits;
      logic [DATA_W-1:0] mag;
      if ($urandom_range(99) < full_pct) return $urandom;
      bits = $urandom_range(20, 4);
      mag  = $urandom & ((32'd1 << bits) - 1);
      return $urandom_range(1) ? -mag : mag;
   endfunction

   function automatic logic [DATA_W-1:0] random_error();
      case ($urandom_range(24))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         default: return random_value(15);
      endcase
   endfunction

   task automatic randomize_config();
      cfg_type           c;
      logic [DATA_W-1:0] a, b;
      c.ticks_per_update = ($urandom_range(9) == 0) ? CNT_W'($urandom_range(12, 5))
                                                    : CNT_W'($urandom_range(4));
      c.gain_prop       = random_value(10);
      c.gain_int_step   = random_value(10);
      c.deriv_coef_now  = random_value(10);
      c.deriv_coef_prev = random_value(10);
      c.deriv_coef_fb   = random_value(10);
      // pi only
      if ($urandom_range(3) == 0) begin
         c.deriv_coef_now  = '0;
         c.deriv_coef_prev = '0;
         c.deriv_coef_fb   = '0;
      end
      a = random_value(20);
      b = random_value(20);
      case ($urandom_range(4))
         0, 1: begin
            c.limit_high = LIMIT_HIGH_RST;
            c.limit_low  = LIMIT_LOW_RST;
         end
         2, 3: begin
            c.limit_high = ($signed(a) > $signed(b)) ? a : b;
            c.limit_low  = ($signed(a) > $signed(b)) ? b : a;
         end
         default: begin
            c.limit_high = a;
            c.limit_low  = b;
         end
      endcase
      write_config(c);
   endtask

   // reset values: ratio 1 and zero gains give a zero drive on every tick
   task automatic test_reset_state();
      idle_pct  = 0;
      stall_pct = 0;
      send_tick(32'h7FFF_FFFF);
      send_tick(32'h8000_0000);
      wait_idle();
   endtask

   // moderate gains with field extremes, then extreme gains for output overflow
   task automatic test_gain_extremes();
      cfg_type c;
      c = '{ticks_per_update: 16'd1, gain_prop: 32'h0001_0000, gain_int_step: 32'h0000_8000,
            deriv_coef_now: 32'h0000_4000, deriv_coef_prev: 32'hFFFF_C000,
            deriv_coef_fb: 32'h0000_8000, limit_high: 32'h0010_0000,
            limit_low: 32'hFFF0_0000};
      write_config(c);
      send_tick(32'h0000_0000);
      send_tick(32'h0000_0001);
      send_tick(32'hFFFF_FFFF);
      send_tick(32'h7FFF_FFFF);
      send_tick(32'h8000_0000);
      send_tick(32'h0003_0000);
      wait_idle();
      c = '{ticks_per_update: 16'd1, gain_prop: 32'h7FFF_FFFF, gain_int_step: 32'h8000_0000,
            deriv_coef_now: 32'h7FFF_FFFF, deriv_coef_prev: 32'h8000_0000,
            deriv_coef_fb: 32'h7FFF_FFFF, limit_high: LIMIT_HIGH_RST,
            limit_low: LIMIT_LOW_RST};
      write_config(c);
      send_tick(32'h7FFF_FFFF);
      send_tick(32'h8000_0000);
      send_tick(32'h8000_0000);
      wait_idle();
   endtask

   // ratio zero updates on every tick
   task automatic test_ratio_zero();
      write_reg(REG_TICKS_PER_UPDATE, '0);
      write_reg(REG_GAIN_INT_STEP, 32'h0000_4000);
      write_reg(REG_LIMIT_HIGH, 32'h0004_0000);
      write_reg(REG_LIMIT_LOW, 32'hFFFC_0000);
      send_tick(32'h0001_0000);
      send_tick(32'hFFFE_0000);
      send_tick(32'h0000_8000);
      wait_idle();
   endtask

   // ratio written below the running count: the next tick updates
   task automatic test_ratio_lowered();
      int i;
      write_reg(REG_TICKS_PER_UPDATE, 32'd10);
      for (i = 0; i < 6; i++) send_tick(random_value(0));
      wait_idle();
      write_reg(REG_TICKS_PER_UPDATE, 32'd3);
      send_tick(32'h0002_0000);
      send_tick(32'hFFFF_0000);
      wait_idle();
   endtask

   // limit_low above limit_high
   task automatic test_limits_crossed();
      write_reg(REG_TICKS_PER_UPDATE, 32'd1);
      write_reg(REG_GAIN_INT_STEP, 32'h0001_0000);
      write_reg(REG_DERIV_COEF_NOW, 32'h0002_0000);
      write_reg(REG_DERIV_COEF_PREV, 32'hFFFF_0000);
      write_reg(REG_DERIV_COEF_FB, 32'h0000_8000);
      write_reg(REG_LIMIT_HIGH, 32'hFFFF_0000);
      write_reg(REG_LIMIT_LOW, 32'h0001_0000);
      send_tick(32'h0002_0000);
      send_tick(32'hFFFE_0000);
      send_tick(32'h0000_0000);
      send_tick(32'h0000_4000);
      wait_idle();
   endtask

   // largest ratio: a run of ticks gives no update, then ratio 1 fires at once
   task automatic test_ratio_max();
      int i;
      write_reg(REG_TICKS_PER_UPDATE, 32'h0000_FFFF);
      write_reg(REG_LIMIT_HIGH, LIMIT_HIGH_RST);
      write_reg(REG_LIMIT_LOW, LIMIT_LOW_RST);
      for (i = 0; i < 20; i++) send_tick(random_error());
      wait_idle();
      write_reg(REG_TICKS_PER_UPDATE, 32'd1);
      send_tick(random_error());
      send_tick(random_error());
      wait_idle();
   endtask

   // random configuration and error samples under one idling pattern
   task automatic test_random_phase(input int sender_idle, input int receiver_stall,
                                    input int n_ticks);
      int i;
      wait_idle();
      randomize_config();
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      for (i = 0; i < n_ticks; i++) send_tick(random_error());
      wait_idle();
   endtask

   // response held off long enough that the unit fills and stalls requests
   task automatic test_response_holdoff();
      int i;
      wait_idle();
      randomize_config();
      write_reg(REG_TICKS_PER_UPDATE, '0);
      idle_pct     = 0;
      stall_pct    = 0;
      hold_request = HOLD_CYCLES;
      for (i = 0; i < 40; i++) send_tick(random_error());
      wait_idle();
   endtask

   initial begin
      model_cfg.ticks_per_update = 16'd1;
      model_cfg.gain_prop        = '0;
      model_cfg.gain_int_step    = '0;
      model_cfg.deriv_coef_now   = '0;
      model_cfg.deriv_coef_prev  = '0;
      model_cfg.deriv_coef_fb    = '0;
      model_cfg.limit_high       = LIMIT_HIGH_RST;
      model_cfg.limit_low        = LIMIT_LOW_RST;
      tick_cnt    = '0;
      integ_state = '0;
      deriv_state = '0;
      error_state = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_gain_extremes();
      test_ratio_zero();
      test_ratio_lowered();
      test_limits_crossed();
      test_ratio_max();
      test_random_phase(0, 0, 90);
      test_random_phase(78, 0, 90);
      test_random_phase(0, 78, 90);
      test_random_phase(16, 16, 90);
      test_response_holdoff();
      wait_idle();

      $display("sent %0d ticks, checked %0d updates, %0d of them saturated",
               ticks_sent, updates_checked, saturated_seen);
      $display("ratios 0, 1, 65535 and lowered, crossed limits, gain extremes, "
               , "random idling and a long response hold-off");
      if (failures == 0 && pending_drive.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d failures, %0d updates never seen", failures, pending_drive.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
